@@ src/vmtd_pkg.sv @@
// Shared types and constants for the virtual-port MAC table dispatcher.
// Depends on nothing; used by vnic_mac_table_dispatch, vmtd_checker and the testbench.
`timescale 1ns / 1ps

package vmtd_pkg;

	localparam int TableEntries = 16;
	localparam int IdPoolBytes  = 32;
	localparam int MaxResults   = 16;
	localparam int MacW         = 48;
	localparam int IdW          = 8;
	localparam logic [MacW-1:0] BroadcastMac = {MacW{1'b1}};

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_DISPATCH = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_DUP_MAC   = 3'd1,
		ST_FULL      = 3'd2,
		ST_NO_IDS    = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_COMPLETE  = 3'd5,
		ST_PASS      = 3'd6,
		ST_RSVD      = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SCAN  = 2'd1,
		S_ALLOC = 2'd2,
		S_SHIFT = 2'd3
	} fsm_t;

endpackage

@@ src/vnic_mac_table_dispatch.sv @@
// Virtual-port MAC table dispatcher: table memory, id pool and sequencer.
// Depends on vmtd_pkg.
`timescale 1ns / 1ps

// Each add, remove or dispatch on a non-empty table walks the table, reading
// one entry per cycle from a synchronous table memory. A remove that hits
// before the last entry shifts the later entries up one slot; an add follows its
// duplicate check with a pool search, one byte of 8 ids at a time. A broadcast
// frame gives one item per entry, up to MaxResults, one per cycle. Results
// appear for one cycle with result_valid and must be taken at once; busy is high
// while an item is in work, and start is accepted only while busy is low.
module vnic_mac_table_dispatch #(
	parameter int TABLE_ENTRIES = vmtd_pkg::TableEntries,
	parameter int ID_POOL_BYTES = vmtd_pkg::IdPoolBytes
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              command,
	input  logic [47:0]             mac_address,
	input  logic [7:0]              entry_id_in,
	output logic                    result_valid,
	output logic [2:0]              status,
	output logic [7:0]              entry_id_out,
	output logic                    deliver,
	output logic                    last
);

	localparam int NW       = $clog2(TABLE_ENTRIES + 1);
	localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int MemW     = vmtd_pkg::MacW + vmtd_pkg::IdW;
	localparam int PoolB    = (ID_POOL_BYTES > 32) ? 32 : ID_POOL_BYTES;
	localparam int PoolIds  = PoolB * 8;
	localparam int BW       = (PoolB > 1) ? $clog2(PoolB) : 1;

	typedef struct packed {
		logic                        emit;
		vmtd_pkg::status_t           st;
		logic [vmtd_pkg::IdW-1:0]    id;
		logic                        dlv;
		logic                        lst;
		logic                        to_idle;
		logic                        to_scan;
		logic                        to_alloc;
		logic                        to_shift;
		logic                        wr_en;
		logic [AW-1:0]               wr_addr;
		logic                        n_inc;
		logic                        n_dec;
		logic                        id_set;
		logic                        id_clr;
	} act_t;

	vmtd_pkg::fsm_t state_q, state_d;
	act_t act;

	logic [NW-1:0]             n_q, lim_q, rd_idx_q, ridx_s1;
	logic                      rdv_s1;
	vmtd_pkg::cmd_t            cmd_q;
	logic [vmtd_pkg::MacW-1:0] mac_q;
	logic [vmtd_pkg::IdW-1:0]  rid_q, new_id;
	logic                      bcast_q;
	logic [BW-1:0]             bidx_q;
	logic [PoolIds-1:0]        pool_q;
	logic [MemW-1:0]           table_q [TABLE_ENTRIES];
	logic [MemW-1:0]           rd_data_s1;
	logic [vmtd_pkg::MacW-1:0] rd_mac;
	logic [vmtd_pkg::IdW-1:0]  rd_id;
	logic                      issue, entry_last, found;
	logic [2:0]                found_bit;
	logic [7:0]                chunk;
	logic                      in_bcast;
	logic [NW-1:0]             in_lim;

	assign rd_mac     = rd_data_s1[MemW-1 -: vmtd_pkg::MacW];
	assign rd_id      = rd_data_s1[vmtd_pkg::IdW-1:0];
	assign issue      = ((state_q == vmtd_pkg::S_SCAN) || (state_q == vmtd_pkg::S_SHIFT))
	                    && (rd_idx_q < lim_q);
	assign entry_last = (NW'(ridx_s1 + 1'b1) == lim_q);
	assign in_bcast   = (mac_address == vmtd_pkg::BroadcastMac);
	assign in_lim     = (in_bcast && (int'(n_q) > vmtd_pkg::MaxResults))
	                    ? NW'(vmtd_pkg::MaxResults) : n_q;
	assign busy       = (state_q != vmtd_pkg::S_IDLE);

	// Lowest free id in the current pool byte.
	always_comb begin
		chunk     = pool_q[bidx_q*8 +: 8];
		found     = 1'b0;
		found_bit = '0;
		for (int b = 7; b >= 0; b--) begin
			if (!chunk[b]) begin
				found     = 1'b1;
				found_bit = 3'(b);
			end
		end
		new_id = vmtd_pkg::IdW'({bidx_q, found_bit});
	end

	// Actions of the current cycle: results, memory writes and count updates.
	always_comb begin
		act         = '0;
		act.st      = vmtd_pkg::ST_DONE;
		act.wr_addr = n_q[AW-1:0];
		case (state_q)
			vmtd_pkg::S_IDLE: begin
				if (start) begin
					case (vmtd_pkg::cmd_t'(command))
						vmtd_pkg::CMD_ADD: begin
							if (n_q == '0) act.to_alloc = 1'b1;
							else act.to_scan = 1'b1;
						end
						vmtd_pkg::CMD_REMOVE: begin
							if (n_q == '0) begin
								act.emit = 1'b1;
								act.st   = vmtd_pkg::ST_NOT_FOUND;
								act.lst  = 1'b1;
							end else begin
								act.to_scan = 1'b1;
							end
						end
						vmtd_pkg::CMD_DISPATCH: begin
							if (n_q == '0) begin
								act.emit = 1'b1;
								act.st   = vmtd_pkg::ST_PASS;
								act.lst  = 1'b1;
							end else begin
								act.to_scan = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			vmtd_pkg::S_SCAN: begin
				if (rdv_s1) begin
					case (cmd_q)
						vmtd_pkg::CMD_ADD: begin
							if (rd_mac == mac_q) begin
								act.emit    = 1'b1;
								act.st      = vmtd_pkg::ST_DUP_MAC;
								act.lst     = 1'b1;
								act.to_idle = 1'b1;
							end else if (entry_last) begin
								if (int'(n_q) >= TABLE_ENTRIES) begin
									act.emit    = 1'b1;
									act.st      = vmtd_pkg::ST_FULL;
									act.lst     = 1'b1;
									act.to_idle = 1'b1;
								end else begin
									act.to_alloc = 1'b1;
								end
							end
						end
						vmtd_pkg::CMD_REMOVE: begin
							if (rd_id == rid_q) begin
								if (entry_last) begin
									act.emit    = 1'b1;
									act.id      = rid_q;
									act.lst     = 1'b1;
									act.to_idle = 1'b1;
									act.n_dec   = 1'b1;
									act.id_clr  = 1'b1;
								end else begin
									act.to_shift = 1'b1;
								end
							end else if (entry_last) begin
								act.emit    = 1'b1;
								act.st      = vmtd_pkg::ST_NOT_FOUND;
								act.lst     = 1'b1;
								act.to_idle = 1'b1;
							end
						end
						default: begin
							if (bcast_q) begin
								act.emit    = 1'b1;
								act.st      = vmtd_pkg::ST_PASS;
								act.id      = rd_id;
								act.dlv     = 1'b1;
								act.lst     = entry_last;
								act.to_idle = entry_last;
							end else if (rd_mac == mac_q) begin
								act.emit    = 1'b1;
								act.st      = vmtd_pkg::ST_COMPLETE;
								act.id      = rd_id;
								act.dlv     = 1'b1;
								act.lst     = 1'b1;
								act.to_idle = 1'b1;
							end else if (entry_last) begin
								act.emit    = 1'b1;
								act.st      = vmtd_pkg::ST_PASS;
								act.lst     = 1'b1;
								act.to_idle = 1'b1;
							end
						end
					endcase
				end
			end
			vmtd_pkg::S_ALLOC: begin
				if (found) begin
					act.emit    = 1'b1;
					act.id      = new_id;
					act.lst     = 1'b1;
					act.to_idle = 1'b1;
					act.wr_en   = 1'b1;
					act.n_inc   = 1'b1;
					act.id_set  = 1'b1;
				end else if (int'(bidx_q) == PoolB - 1) begin
					act.emit    = 1'b1;
					act.st      = vmtd_pkg::ST_NO_IDS;
					act.lst     = 1'b1;
					act.to_idle = 1'b1;
				end
			end
			vmtd_pkg::S_SHIFT: begin
				if (rdv_s1) begin
					act.wr_en   = 1'b1;
					act.wr_addr = AW'(ridx_s1 - 1'b1);
					if (entry_last) begin
						act.emit    = 1'b1;
						act.id      = rid_q;
						act.lst     = 1'b1;
						act.to_idle = 1'b1;
						act.n_dec   = 1'b1;
						act.id_clr  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		if (act.to_idle) state_d = vmtd_pkg::S_IDLE;
		else if (act.to_alloc) state_d = vmtd_pkg::S_ALLOC;
		else if (act.to_shift) state_d = vmtd_pkg::S_SHIFT;
		else if (act.to_scan) state_d = vmtd_pkg::S_SCAN;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vmtd_pkg::S_IDLE;
			n_q          <= '0;
			pool_q       <= '0;
			rdv_s1       <= 1'b0;
			result_valid <= 1'b0;
			rd_idx_q     <= '0;
			bidx_q       <= '0;
		end else begin
			state_q      <= state_d;
			rdv_s1       <= issue;
			result_valid <= act.emit;
			if (state_q == vmtd_pkg::S_IDLE) begin
				rd_idx_q <= '0;
				bidx_q   <= '0;
			end else begin
				if (issue) rd_idx_q <= NW'(rd_idx_q + 1'b1);
				if (state_q == vmtd_pkg::S_ALLOC) bidx_q <= BW'(bidx_q + 1'b1);
			end
			if (act.n_inc) n_q <= NW'(n_q + 1'b1);
			if (act.n_dec) n_q <= NW'(n_q - 1'b1);
			if (act.id_set) pool_q[new_id] <= 1'b1;
			if (act.id_clr && (int'(rid_q) < PoolIds)) pool_q[rid_q] <= 1'b0;
		end
	end

	// Item fields and result payload.
	always_ff @(posedge clk) begin
		if ((state_q == vmtd_pkg::S_IDLE) && start) begin
			cmd_q   <= vmtd_pkg::cmd_t'(command);
			mac_q   <= mac_address;
			rid_q   <= entry_id_in;
			bcast_q <= in_bcast;
			lim_q   <= (vmtd_pkg::cmd_t'(command) == vmtd_pkg::CMD_DISPATCH) ? in_lim : n_q;
		end
		ridx_s1      <= rd_idx_q;
		status       <= act.st;
		entry_id_out <= act.id;
		deliver      <= act.dlv;
		last         <= act.lst;
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (act.wr_en) begin
			if (state_q == vmtd_pkg::S_SHIFT) table_q[act.wr_addr] <= rd_data_s1;
			else table_q[act.wr_addr] <= {mac_q, new_id};
		end
		rd_data_s1 <= table_q[rd_idx_q[AW-1:0]];
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(n_q) <= TABLE_ENTRIES) else $error("entry count above table size");
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> ($past(state_q) == vmtd_pkg::S_SCAN || $past(state_q) == vmtd_pkg::S_SHIFT))
		else $error("table read outside a walk");
	a_deliver_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && deliver) |->
		(status == vmtd_pkg::ST_COMPLETE || status == vmtd_pkg::ST_PASS))
		else $error("delivery with a non-frame status");
	a_non_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> (deliver && busy))
		else $error("non-final item outside a broadcast");

endmodule

@@ bench/vmtd_checker.sv @@
// Checker for the MAC table dispatcher: predicts the results of each accepted item
// and compares them with the results the block produces.
// Depends on vmtd_pkg.
`timescale 1ns / 1ps

module vmtd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  command,
	input  logic [47:0] mac_address,
	input  logic [7:0]  entry_id_in,
	input  logic        result_valid,
	input  logic [2:0]  status,
	input  logic [7:0]  entry_id_out,
	input  logic        deliver,
	input  logic        last,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		vmtd_pkg::status_t st;
		logic [7:0]        id;
		logic              dlv;
		logic              lst;
	} vport_result_t;

	localparam int PoolIds = (vmtd_pkg::IdPoolBytes * 8 > 256) ? 256
		: vmtd_pkg::IdPoolBytes * 8;

	// Shadow copy of the table and the id pool.
	logic [47:0]   shadow_mac [vmtd_pkg::TableEntries];
	logic [7:0]    shadow_id  [vmtd_pkg::TableEntries];
	int            shadow_n;
	logic          id_taken   [256];
	vport_result_t owed [$];

	// Works out the results of one item and updates the shadow state.
	task automatic predict_item(input vmtd_pkg::cmd_t cmd, input logic [47:0] mac,
			input logic [7:0] rid);
		int hit;
		int free_id;
		hit = -1;
		free_id = -1;
		case (cmd)
			vmtd_pkg::CMD_ADD: begin
				for (int i = 0; i < shadow_n; i++)
					if (shadow_mac[i] == mac) hit = i;
				if (hit >= 0) begin
					owed.push_back('{vmtd_pkg::ST_DUP_MAC, 8'd0, 1'b0, 1'b1});
				end else if (shadow_n >= vmtd_pkg::TableEntries) begin
					owed.push_back('{vmtd_pkg::ST_FULL, 8'd0, 1'b0, 1'b1});
				end else begin
					for (int k = PoolIds - 1; k >= 0; k--)
						if (!id_taken[k]) free_id = k;
					if (free_id < 0) begin
						owed.push_back('{vmtd_pkg::ST_NO_IDS, 8'd0, 1'b0, 1'b1});
					end else begin
						id_taken[free_id] = 1'b1;
						shadow_mac[shadow_n] = mac;
						shadow_id[shadow_n] = free_id[7:0];
						shadow_n++;
						owed.push_back('{vmtd_pkg::ST_DONE, free_id[7:0], 1'b0, 1'b1});
					end
				end
			end
			vmtd_pkg::CMD_REMOVE: begin
				for (int i = shadow_n - 1; i >= 0; i--)
					if (shadow_id[i] == rid) hit = i;
				if (hit < 0) begin
					owed.push_back('{vmtd_pkg::ST_NOT_FOUND, 8'd0, 1'b0, 1'b1});
				end else begin
					// Later entries move up one slot to keep the table compact.
					for (int j = hit; j + 1 < shadow_n; j++) begin
						shadow_mac[j] = shadow_mac[j + 1];
						shadow_id[j] = shadow_id[j + 1];
					end
					shadow_n--;
					id_taken[rid] = 1'b0;
					owed.push_back('{vmtd_pkg::ST_DONE, rid, 1'b0, 1'b1});
				end
			end
			vmtd_pkg::CMD_DISPATCH: begin
				if (mac == vmtd_pkg::BroadcastMac) begin
					if (shadow_n == 0) begin
						owed.push_back('{vmtd_pkg::ST_PASS, 8'd0, 1'b0, 1'b1});
					end else begin
						for (int i = 0; i < shadow_n && i < vmtd_pkg::MaxResults; i++)
							owed.push_back('{vmtd_pkg::ST_PASS, shadow_id[i], 1'b1,
								(i == shadow_n - 1 || i == vmtd_pkg::MaxResults - 1)});
					end
				end else begin
					for (int i = shadow_n - 1; i >= 0; i--)
						if (shadow_mac[i] == mac) hit = i;
					if (hit >= 0)
						owed.push_back('{vmtd_pkg::ST_COMPLETE, shadow_id[hit], 1'b1, 1'b1});
					else
						owed.push_back('{vmtd_pkg::ST_PASS, 8'd0, 1'b0, 1'b1});
				end
			end
			default: begin
			end
		endcase
	endtask

	// Results are checked before the item accepted on the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		vport_result_t want;
		if (!arst_n) begin
			shadow_n = 0;
			for (int k = 0; k < 256; k++) id_taken[k] = 1'b0;
			owed.delete();
			errors = 0;
		end else begin
			if (result_valid) begin
				if (owed.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result status=%0d id=%0d",
							$realtime, status, entry_id_out);
				end else begin
					want = owed.pop_front();
					if (status !== want.st || entry_id_out !== want.id ||
							deliver !== want.dlv || last !== want.lst) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch exp st=%0d id=%0d dlv=%b last=%b",
								" got st=%0d id=%0d dlv=%b last=%b"},
								$realtime, want.st, want.id, want.dlv, want.lst,
								status, entry_id_out, deliver, last);
					end
				end
			end
			if (start && !busy)
				predict_item(vmtd_pkg::cmd_t'(command), mac_address, entry_id_in);
		end
		pending = owed.size();
	end

endmodule

@@ bench/vnic_mac_table_dispatch_tb.sv @@
// Testbench top for vnic_mac_table_dispatch: clock, reset, stimulus and verdict.
// Depends on vmtd_pkg, vnic_mac_table_dispatch and vmtd_checker.
`timescale 1ns / 1ps

module vnic_mac_table_dispatch_tb;

	localparam int IdleLimit = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [47:0] mac_address;
	logic [7:0]  entry_id_in;
	logic        result_valid;
	logic [2:0]  status;
	logic [7:0]  entry_id_out;
	logic        deliver;
	logic        last;
	int          pending;
	int          errors;
	logic        ready_seen;
	int          idle_cycles;
	logic [47:0] known_macs [$];
	int          burst_left;

	vnic_mac_table_dispatch uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .mac_address(mac_address), .entry_id_in(entry_id_in),
		.result_valid(result_valid), .status(status), .entry_id_out(entry_id_out),
		.deliver(deliver), .last(last)
	);

	vmtd_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .mac_address(mac_address), .entry_id_in(entry_id_in),
		.result_valid(result_valid), .status(status), .entry_id_out(entry_id_out),
		.deliver(deliver), .last(last), .pending(pending), .errors(errors)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Busy is stable between the falling and the next rising edge.
	always @(negedge clk) ready_seen <= !busy;

	// Watchdog on cycles in which neither an item nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Presents one item and holds it until the block takes it.
	task automatic send_item(input vmtd_pkg::cmd_t cmd, input logic [47:0] mac,
			input logic [7:0] rid);
		start <= 1'b1;
		command <= cmd;
		mac_address <= mac;
		entry_id_in <= rid;
		do @(posedge clk); while (!ready_seen);
		if (cmd == vmtd_pkg::CMD_ADD) known_macs.push_back(mac);
		if (known_macs.size() > 24) void'(known_macs.pop_front());
	endtask

	// Inserts a random gap between bursts of items.
	task automatic pace;
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [47:0] rand_mac;
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[47:0];
	endfunction

	initial begin
		vmtd_pkg::cmd_t cmd;
		logic [47:0]    mac;
		logic [7:0]     rid;
		int             pick;
		arst_n = 1'b0;
		start = 1'b0;
		command = vmtd_pkg::CMD_NONE;
		mac_address = '0;
		entry_id_in = '0;
		ready_seen = 1'b0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, extremes, full table and each status but ST_NO_IDS.
		send_item(vmtd_pkg::CMD_DISPATCH, vmtd_pkg::BroadcastMac, 8'd0);
		send_item(vmtd_pkg::CMD_DISPATCH, 48'h0, 8'd0);
		send_item(vmtd_pkg::CMD_REMOVE, 48'h0, 8'd255);
		send_item(vmtd_pkg::CMD_ADD, 48'h0, 8'd0);
		send_item(vmtd_pkg::CMD_ADD, vmtd_pkg::BroadcastMac, 8'd0);
		send_item(vmtd_pkg::CMD_ADD, 48'h0, 8'd0);
		for (int i = 2; i < 16; i++) send_item(vmtd_pkg::CMD_ADD, rand_mac(), 8'hff);
		send_item(vmtd_pkg::CMD_ADD, 48'h123456789abc, 8'd0);
		send_item(vmtd_pkg::CMD_DISPATCH, vmtd_pkg::BroadcastMac, 8'd0);
		send_item(vmtd_pkg::CMD_DISPATCH, 48'h0, 8'd0);
		send_item(vmtd_pkg::CMD_REMOVE, 48'hffff_ffff_ffff, 8'd0);
		send_item(vmtd_pkg::CMD_NONE, rand_mac(), 8'd3);
		send_item(vmtd_pkg::CMD_DISPATCH, vmtd_pkg::BroadcastMac, 8'd0);
		send_item(vmtd_pkg::CMD_ADD, 48'h8000_0000_0001, 8'd0);

		// Hold off until the block has drained every result.
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		// Random part, weighted toward dispatches and adds, removes of live ids and known MACs.
		for (int n = 0; n < 160; n++) begin
			pace();
			pick = $urandom_range(0, 99);
			rid = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 20));
			mac = rand_mac();
			if (pick < 30) begin
				cmd = vmtd_pkg::CMD_ADD;
				if ($urandom_range(0, 5) == 0 && known_macs.size() > 0)
					mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
			end else if (pick < 55) begin
				cmd = vmtd_pkg::CMD_REMOVE;
			end else if (pick < 95) begin
				cmd = vmtd_pkg::CMD_DISPATCH;
				if (pick < 70) mac = vmtd_pkg::BroadcastMac;
				else if (pick < 88 && known_macs.size() > 0)
					mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
			end else begin
				cmd = vmtd_pkg::CMD_NONE;
			end
			send_item(cmd, mac, rid);
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
